// File: hw/rtl/ftfp_pkg.sv
`timescale 1ns / 1ps

package ftfp_pkg;

  localparam int WinLen       = 25;
  localparam int StoreLen     = WinLen - 1;
  localparam int FillW        = $clog2(WinLen);
  localparam int HdrLen       = 4;
  localparam int RdgBytes     = 3;
  localparam int RdgW         = 8 * RdgBytes;
  localparam int NumRdg       = 6;
  localparam int NumForce     = 3;
  localparam int RdgIdxW      = $clog2(NumRdg);
  localparam int GainW        = 32;
  localparam int ResW         = 56;
  localparam int CfgIdxW      = 8;
  localparam int QueueDepthDef = 2;

  localparam logic [7:0] Hdr0 = 8'h00;
  localparam logic [7:0] Hdr1 = 8'h17;
  localparam logic [7:0] Hdr2 = 8'h80;
  localparam logic [7:0] Hdr3 = 8'h00;

  localparam logic [GainW-1:0] ForceGainRst  = 32'd4294967;
  localparam logic [GainW-1:0] TorqueGainRst = 32'd42950;

  localparam logic [CfgIdxW-1:0] RegForceGain  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTorqueGain = 8'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] force_x;
    logic signed [ResW-1:0] force_y;
    logic signed [ResW-1:0] force_z;
    logic signed [ResW-1:0] torque_x;
    logic signed [ResW-1:0] torque_y;
    logic signed [ResW-1:0] torque_z;
  } res_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [GainW-1:0]   value;
  } cfg_item_t;

  typedef logic [NumRdg-1:0][RdgW-1:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/ftfp_chan_if.sv
`timescale 1ns / 1ps

interface ftfp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

// File: hw/rtl/ftfp_front.sv
`timescale 1ns / 1ps

module ftfp_front import ftfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ftfp_chan_if.sink    rx_i,
  input  q_stat_t      q_stat_i,
  output logic         push_o,
  output frame_t       frame_o
);

  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       win_q [StoreLen];
  logic             accept;
  logic             full;
  logic             hdr_ok;

  assign full   = (fill_q == FillW'(StoreLen));
  assign hdr_ok = (win_q[0] == Hdr0) && (win_q[1] == Hdr1) &&
                  (win_q[2] == Hdr2) && (win_q[3] == Hdr3);

  assign rx_i.ready = !full || !q_stat_i.full;
  assign accept     = rx_i.valid && rx_i.ready;
  assign push_o     = accept && full && hdr_ok;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end else if (hdr_ok) begin
        fill_d = '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumRdg; k++) begin
      frame_o[k] = {win_q[HdrLen + RdgBytes*k],
                    win_q[HdrLen + RdgBytes*k + 1],
                    win_q[HdrLen + RdgBytes*k + 2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // oldest byte at index 0, newest enters at the top
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < StoreLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[StoreLen-1] <= rx_i.data.rx_byte;
    end
  end

endmodule

// File: hw/rtl/ftfp_queue.sv
`timescale 1ns / 1ps

module ftfp_queue import ftfp_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  frame_t  frame_i,
  input  logic    pop_i,
  output frame_t  head_o,
  output q_stat_t stat_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

// File: hw/rtl/ftfp_back.sv
`timescale 1ns / 1ps

module ftfp_back import ftfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftfp_chan_if.sink   cfg_i,
  ftfp_chan_if.source res_o,
  input  q_stat_t     q_stat_i,
  input  frame_t      head_i,
  output logic        pop_o
);

  logic [GainW-1:0]      force_gain_q, force_gain_d;
  logic [GainW-1:0]      torque_gain_q, torque_gain_d;
  logic [RdgIdxW-1:0]    idx_q, idx_d;
  logic                  busy_q, busy_d;
  logic                  out_valid_q, out_valid_d;
  logic [ResW-1:0]       res_q [NumRdg];
  logic                  start;
  logic                  last;
  logic [RdgW-1:0]       rdg;
  logic [GainW-1:0]      gain_sel;
  logic signed [ResW:0]  prod;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    force_gain_d  = force_gain_q;
    torque_gain_d = torque_gain_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegForceGain:  force_gain_d  = cfg_i.data.value;
        RegTorqueGain: torque_gain_d = cfg_i.data.value;
        default: ;
      endcase
    end
  end

  assign start    = !busy_q && !out_valid_q && !q_stat_i.empty;
  assign last     = busy_q && (idx_q == RdgIdxW'(NumRdg - 1));
  assign pop_o    = last;
  assign rdg      = head_i[idx_q];
  assign gain_sel = (idx_q < RdgIdxW'(NumForce)) ? force_gain_q : torque_gain_q;
  assign prod     = $signed(rdg) * $signed({1'b0, gain_sel});

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (last) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end else if (busy_q) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_gain_q  <= ForceGainRst;
      torque_gain_q <= TorqueGainRst;
      busy_q        <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      force_gain_q  <= force_gain_d;
      torque_gain_q <= torque_gain_d;
      busy_q        <= busy_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      res_q[idx_q] <= prod[ResW-1:0];
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.data.force_x  = res_q[0];
  assign res_o.data.force_y  = res_q[1];
  assign res_o.data.force_z  = res_q[2];
  assign res_o.data.torque_x = res_q[3];
  assign res_o.data.torque_y = res_q[4];
  assign res_o.data.torque_z = res_q[5];

endmodule

// File: hw/rtl/force_torque_frame_parser.sv
`timescale 1ns / 1ps
// force/torque frame parser
// rx_i: one received serial byte per item, taken every cycle while ready is high
// res_o: one item per recognised frame, six signed q23.32 readings
// cfg_i: register writes, index 0 force gain, index 1 torque gain, always ready
// bytes enter a 25-byte window; once full, the header 00 17 80 00 is checked
// at the oldest position; a match queues the frame and empties the window,
// a mismatch drops the oldest byte
// throughput: one byte per cycle unless the window and the frame queue are both full
// the result item is valid once the multiply stage, when free, has taken the
// queued frame and worked through its readings; the six products share one
// 24 x 33 bit multiplier, one reading per cycle
// a frame queue of QueueDepth entries sits between window and multiplier
// when the receiver stalls the result holds and the window keeps taking bytes;
// rx_i.ready drops only when the window is full and the frame queue is full
// reset empties the window and queue and loads the default gains
module force_torque_frame_parser import ftfp_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftfp_chan_if.sink   rx_i,
  ftfp_chan_if.source res_o,
  ftfp_chan_if.sink   cfg_i
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  frame_t  frame;
  frame_t  head;

  ftfp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .frame_o  (frame)
  );

  ftfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (frame),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  ftfp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .res_o    (res_o),
    .q_stat_i (q_stat),
    .head_i   (head),
    .pop_o    (pop)
  );

endmodule

// File: hw/rtl/ftfp_checker.sv
`timescale 1ns / 1ps

module ftfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  ftfp_chan_if.sink   rx_i,
  ftfp_chan_if.source res_o,
  ftfp_chan_if.sink   cfg_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.data))
    else $error("result item changed while stalled");

  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready |=> !res_o.valid ##1 !res_o.valid ##1 !res_o.valid)
    else $error("result item followed a delivered one too soon");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.ready)
    else $error("configuration port not ready");

  a_rx_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> rx_i.ready)
    else $error("byte channel not ready after reset");

endmodule

bind force_torque_frame_parser ftfp_checker u_ftfp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .rx_i   (rx_i),
  .res_o  (res_o),
  .cfg_i  (cfg_i)
);
